@@ src/deqi_pkg.sv @@
// Shared constants, codes and command type for the double-ended queue core.
`default_nettype none

package deqi_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 8;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 5;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_INSERT     = 3'd4,
		KIND_ERASE      = 3'd5,
		KIND_READ       = 3'd6,
		KIND_CLEAR      = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Broadcast to every cell: what to do this cycle and where.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [CNT_W-1:0]  pos;
		logic [DATA_W-1:0] value;
		logic              rd_en;
		logic [CNT_W-1:0]  rd_pos;
		logic [CNT_W-1:0]  bk_pos;
	} deqi_cmd_t;

endpackage

`default_nettype wire

@@ src/deqi_cell.sv @@
// One storage cell of the queue row: holds one word, shifts or loads on command.
`default_nettype none

module deqi_cell
	import deqi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire deqi_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic      [DATA_W-1:0] data,
	output logic      [DATA_W-1:0] rd_tap,
	output logic      [DATA_W-1:0] bk_tap
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic [CNT_W-1:0]  my_idx;

	assign my_idx = CNT_W'(idx);

	// Insert: cells above the gap take from the left, the gap cell loads.
	// Erase: cells from the hole upward take from the right.
	always_comb begin
		data_d = data_q;
		if (cmd.ins) begin
			if (my_idx > cmd.pos)
				data_d = left_data;
			else if (my_idx == cmd.pos)
				data_d = cmd.value;
		end else if (cmd.del) begin
			if (my_idx >= cmd.pos)
				data_d = right_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data   = data_q;
	assign rd_tap = (cmd.rd_en && my_idx == cmd.rd_pos) ? data_q : '0;
	assign bk_tap = (my_idx == cmd.bk_pos) ? data_q : '0;

endmodule

`default_nettype wire

@@ src/double_ended_queue_with_insert_core.sv @@
// Top level of the bounded double-ended queue with positional insert and erase.
`default_nettype none

// Bounded double-ended queue held in a row of DEPTH cells, index 0 at the
// front. A request is taken at any rising edge with start high; busy is
// always low, so a new request may follow in every cycle. Each request
// yields exactly one result word in the next cycle, shown for that single
// cycle with done high; the receiver cannot stall, so sample it then.
// Each cell decides locally whether to hold, take from its left or right
// neighbour, or load the new word, so a whole shift completes at once.
// read_value is the word popped, erased or read (zero otherwise);
// front_value and back_value show the queue after the request (zero when
// empty); status is ok, full refused, empty refused or bad position. A full
// check precedes the position check for insert, and an empty check precedes
// it for erase and read. Clear always succeeds.

module double_ended_queue_with_insert_core
	import deqi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [4:0]  position,
	input  wire logic [7:0]  value,
	output logic             done,
	output logic      [7:0]  read_value,
	output logic      [7:0]  front_value,
	output logic      [7:0]  back_value,
	output logic      [4:0]  occupancy,
	output logic      [1:0]  status
);

	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic [DATA_W-1:0] read_value_q;
	status_t           status_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  count_ext;
	kind_t             kind_in;
	deqi_cmd_t         cmd;
	status_t           st_d;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] rd_taps   [DEPTH];
	logic [DATA_W-1:0] bk_taps   [DEPTH];
	logic [DATA_W-1:0] rd_word;
	logic [DATA_W-1:0] bk_word;

	assign busy      = 1'b0;
	assign accept    = start;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign pos_ext   = CMP_W'(position);
	assign count_ext = CMP_W'(count_q);
	assign kind_in   = kind_t'(kind);

	// Decode the request into a cell command; drop it unless accepted.
	always_comb begin
		cmd        = '0;
		cmd.value  = DATA_W'(value);
		cmd.bk_pos = count_q - CNT_W'(1);
		st_d       = ST_OK;
		unique case (kind_in)
			KIND_PUSH_FRONT: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd.ins = 1'b1;
					cmd.pos = '0;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd.ins = 1'b1;
					cmd.pos = count_q;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					cmd.del    = 1'b1;
					cmd.pos    = '0;
					cmd.rd_en  = 1'b1;
					cmd.rd_pos = '0;
				end
			end
			KIND_POP_BACK: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					cmd.del    = 1'b1;
					cmd.pos    = count_q - CNT_W'(1);
					cmd.rd_en  = 1'b1;
					cmd.rd_pos = count_q - CNT_W'(1);
				end
			end
			KIND_INSERT: begin
				if (full) st_d = ST_FULL;
				else if (pos_ext > count_ext) st_d = ST_BADPOS;
				else begin
					cmd.ins = 1'b1;
					cmd.pos = CNT_W'(position);
				end
			end
			KIND_ERASE, KIND_READ: begin
				if (empty) st_d = ST_EMPTY;
				else if (pos_ext >= count_ext) st_d = ST_BADPOS;
				else begin
					cmd.del    = (kind_in == KIND_ERASE);
					cmd.pos    = CNT_W'(position);
					cmd.rd_en  = 1'b1;
					cmd.rd_pos = CNT_W'(position);
				end
			end
			KIND_CLEAR: begin
				st_d = ST_OK;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
		if (!accept) begin
			cmd.ins   = 1'b0;
			cmd.del   = 1'b0;
			cmd.rd_en = 1'b0;
		end
	end

	// Row of cells; the ends see zero beyond the row.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end
		deqi_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.rd_tap     (rd_taps[i]),
			.bk_tap     (bk_taps[i])
		);
	end

	// Gather the one-hot taps: at most one cell drives each.
	always_comb begin
		rd_word = '0;
		bk_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | rd_taps[i];
			bk_word = bk_word | bk_taps[i];
		end
	end

	// Hold fill count, strobe and status; the read word is captured before the shift below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				status_q <= st_d;
				if (kind_in == KIND_CLEAR)
					count_q <= '0;
				else if (cmd.ins)
					count_q <= count_q + CNT_W'(1);
				else if (cmd.del)
					count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			read_value_q <= rd_word;
	end

	// Front and back come from the updated row during the result cycle.
	assign done        = done_q;
	assign read_value  = 8'(read_value_q);
	assign front_value = empty ? 8'd0 : 8'(cell_data[0]);
	assign back_value  = empty ? 8'd0 : 8'(bk_word);
	assign occupancy   = 5'(count_q);
	assign status      = status_q;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the bounded double-ended queue core.
`timescale 1ns / 1ps

module tb;
	import deqi_pkg::*;

	// Cycles without any word taken or returned before the run is abandoned.
	// The longest input gap from pick_gap is far shorter, and the core answers in the next cycle.
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_WORDS = 2000;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [7:0] read_value;
		logic [7:0] front_value;
		logic [7:0] back_value;
		logic [4:0] occupancy;
		status_t    status;
	} queue_result_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] kind;
	logic [4:0] position;
	logic [7:0] value;
	logic       done;
	logic [7:0] read_value;
	logic [7:0] front_value;
	logic [7:0] back_value;
	logic [4:0] occupancy;
	logic [1:0] status;

	// Shadow copy of the queue: index 0 is the front.
	logic [7:0]    held_words [DEPTH];
	int            held_count;
	// Results still owed by the core, oldest first.
	queue_result_t owed_results [$];
	int            mismatches;
	int            stall_cycles;

	double_ended_queue_with_insert_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.position    (position),
		.value       (value),
		.done        (done),
		.read_value  (read_value),
		.front_value (front_value),
		.back_value  (back_value),
		.occupancy   (occupancy),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow queue and return the word the core owes.
	// Full is checked before the position for insert, empty before the
	// position for erase and read; a refused request reports a zero read value.
	function automatic queue_result_t apply_request(kind_t k, logic [4:0] p,
			logic [7:0] v);
		queue_result_t r;
		int            at;
		at = int'(p);
		r.read_value = '0;
		r.status     = ST_OK;
		case (k)
			KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else if (k == KIND_INSERT && at > held_count) begin
					r.status = ST_BADPOS;
				end else begin
					if (k == KIND_PUSH_FRONT)
						at = 0;
					else if (k == KIND_PUSH_BACK)
						at = held_count;
					// Open a gap at the slot and drop the new word in.
					for (int i = held_count; i > at; i--)
						held_words[i] = held_words[i-1];
					held_words[at] = v;
					held_count++;
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK, KIND_ERASE, KIND_READ: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else if ((k == KIND_ERASE || k == KIND_READ)
						&& at >= held_count) begin
					r.status = ST_BADPOS;
				end else begin
					if (k == KIND_POP_FRONT)
						at = 0;
					else if (k == KIND_POP_BACK)
						at = held_count - 1;
					r.read_value = held_words[at];
					if (k != KIND_READ) begin
						// Close the gap behind the removed word.
						for (int i = at; i + 1 < held_count; i++)
							held_words[i] = held_words[i+1];
						held_count--;
					end
				end
			end
			default: begin
				held_count = 0;
			end
		endcase
		r.front_value = (held_count == 0) ? 8'h00 : held_words[0];
		r.back_value  = (held_count == 0) ? 8'h00 : held_words[held_count-1];
		r.occupancy   = 5'(held_count);
		return r;
	endfunction

	// One process watches both sides at the rising edge, so the expectation
	// for a word is always queued before its result can be checked.
	always @(posedge clk) begin : watch_ports
		queue_result_t want;
		queue_result_t got;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;

			if (start && !busy)
				owed_results.insert(owed_results.size(),
					apply_request(kind_t'(kind), position, value));

			if (done) begin
				got.read_value  = read_value;
				got.front_value = front_value;
				got.back_value  = back_value;
				got.occupancy   = occupancy;
				got.status      = status_t'(status);
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: word with none owed: rd=%h fr=%h bk=%h occ=%0d st=%s",
							$realtime, got.read_value, got.front_value,
							got.back_value, got.occupancy, got.status.name());
				end else begin
					want = owed_results[0];
					owed_results.delete(0);
					if (got.read_value !== want.read_value
							|| got.front_value !== want.front_value
							|| got.back_value !== want.back_value
							|| got.occupancy !== want.occupancy
							|| got.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: mismatch exp rd=%h fr=%h bk=%h occ=%0d st=%s",
								$realtime, want.read_value, want.front_value,
								want.back_value, want.occupancy, want.status.name());
							$display("%0t:          got rd=%h fr=%h bk=%h occ=%0d st=%s",
								$realtime, got.read_value, got.front_value,
								got.back_value, got.occupancy, got.status.name());
						end
					end
				end
			end

			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, stall_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Present one request from a falling edge and hold it until taken; return
	// on the following falling edge with start still high.
	task automatic send_word(kind_t k, logic [4:0] p, logic [7:0] v);
		start    <= 1'b1;
		kind     <= k;
		position <= p;
		value    <= v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Drop start and put junk on the fields; n gives the length of the gap.
	task automatic pause_input(int n);
		repeat (n) begin
			start    <= 1'b0;
			kind     <= 3'($urandom);
			position <= 5'($urandom);
			value    <= 8'($urandom);
			@(negedge clk);
		end
	endtask

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Refusals on an empty queue, both ends, insert at the front, middle and
	// back, reads and erases at the edges of the valid range, and clear.
	task automatic test_basic_requests();
		send_word(KIND_POP_FRONT, 5'd0, 8'h00);
		send_word(KIND_POP_BACK, 5'd0, 8'h00);
		send_word(KIND_ERASE, 5'd31, 8'h00);
		send_word(KIND_READ, 5'd0, 8'hFF);
		send_word(KIND_INSERT, 5'd1, 8'h5A);
		send_word(KIND_INSERT, 5'd0, 8'h00);
		send_word(KIND_PUSH_FRONT, 5'd16, 8'hFF);
		send_word(KIND_PUSH_BACK, 5'd0, 8'h81);
		pause_input(pick_gap());
		send_word(KIND_INSERT, 5'd3, 8'h7E);
		send_word(KIND_INSERT, 5'd1, 8'hC3);
		send_word(KIND_READ, 5'd0, 8'h00);
		send_word(KIND_READ, 5'd4, 8'h00);
		send_word(KIND_READ, 5'd5, 8'h00);
		send_word(KIND_ERASE, 5'd31, 8'h00);
		send_word(KIND_ERASE, 5'd2, 8'h00);
		send_word(KIND_POP_BACK, 5'd0, 8'h00);
		send_word(KIND_POP_FRONT, 5'd0, 8'h00);
		send_word(KIND_CLEAR, 5'd0, 8'h00);
		send_word(KIND_READ, 5'd0, 8'h00);
	endtask

	// Fill to capacity, then check that full is reported ahead of a bad
	// position and that the last slot can be read and erased.
	task automatic test_full_queue();
		for (int i = 0; i < DEPTH; i++) begin
			if (i % 2 == 0)
				send_word(KIND_PUSH_BACK, 5'($urandom), 8'($urandom));
			else
				send_word(KIND_INSERT, 5'($urandom_range(0, held_count)), 8'($urandom));
		end
		send_word(KIND_PUSH_FRONT, 5'd0, 8'hA5);
		send_word(KIND_INSERT, 5'd31, 8'h3C);
		send_word(KIND_READ, 5'd31, 8'h00);
		send_word(KIND_READ, 5'(DEPTH - 1), 8'h00);
		send_word(KIND_ERASE, 5'(DEPTH - 1), 8'h00);
		send_word(KIND_READ, 5'(DEPTH - 1), 8'h00);
		send_word(KIND_CLEAR, 5'd0, 8'h00);
	endtask

	// Random traffic in stretches that tend to grow, shrink or hold the
	// queue level, so it swings between empty and full; some stretches
	// run back to back.
	task automatic test_random_traffic();
		int    grow_pct;
		int    roll;
		bit    back_to_back;
		kind_t k;
		logic [4:0] p;
		grow_pct     = 50;
		back_to_back = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       grow_pct = 70;
					1:       grow_pct = 25;
					default: grow_pct = 50;
				endcase
				back_to_back = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				k = KIND_CLEAR;
			end else if (roll < grow_pct) begin
				case ($urandom_range(0, 2))
					0:       k = KIND_PUSH_FRONT;
					1:       k = KIND_PUSH_BACK;
					default: k = KIND_INSERT;
				endcase
			end else if (roll < grow_pct + 12) begin
				k = KIND_READ;
			end else begin
				case ($urandom_range(0, 2))
					0:       k = KIND_POP_FRONT;
					1:       k = KIND_POP_BACK;
					default: k = KIND_ERASE;
				endcase
			end
			// Mostly a position that lands in or just past the queue;
			// sometimes anything the field can carry.
			if ($urandom_range(0, 9) == 0)
				p = 5'($urandom_range(0, 31));
			else
				p = 5'($urandom_range(0, held_count));
			send_word(k, p, 8'($urandom_range(0, 255)));
			if (!back_to_back)
				pause_input(pick_gap());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = '0;
		position     = '0;
		value        = '0;
		held_count   = 0;
		mismatches   = 0;
		stall_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_requests();
		pause_input(pick_gap());
		test_full_queue();
		pause_input(pick_gap());
		test_random_traffic();
		start <= 1'b0;

		// Drain what is still owed, then keep watching for stray words.
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
